FILE: sv/erm_pkg.sv
// shared types, constants and helpers for the expert residency manager
`default_nettype none
package erm_pkg;
	localparam int LAYERS   = 32;
	localparam int EXPERTS  = 64;
	localparam int LW       = $clog2(LAYERS);
	localparam int EW       = $clog2(EXPERTS);
	localparam int AW       = LW + EW;
	localparam int DEPTH    = LAYERS * EXPERTS;
	localparam int SCORE_W  = 32;
	localparam int CNT_W    = 16;
	localparam int SLOT_W   = 7;
	localparam int TOT_W    = 48;
	localparam int TICK_W   = 20;

	localparam logic [SLOT_W-1:0] NOT_RES = 7'h40;
	localparam logic [TOT_W-1:0]  SAT48   = {TOT_W{1'b1}};

	localparam logic [1:0] KIND_ACCESS = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_REPORT = 2'd2;

	localparam logic FUNC_ACCESS = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	localparam logic [2:0] REG_NUM_EXPERTS  = 3'd0;
	localparam logic [2:0] REG_NUM_RESIDENT = 3'd1;
	localparam logic [2:0] REG_NUM_LAYERS   = 3'd2;
	localparam logic [2:0] REG_DECAY        = 3'd3;
	localparam logic [2:0] REG_HYSTERESIS   = 3'd4;
	localparam logic [2:0] REG_PERIOD       = 3'd5;

	// effective configuration as seen by the datapath
	typedef struct packed {
		logic [6:0]         ne;
		logic [5:0]         nr;
		logic [5:0]         nl;
		logic [15:0]        decay;
		logic [31:0]        hyst;
		logic [TICK_W-1:0]  period;
	} cfg_t;

	typedef struct packed {
		logic          func;
		logic          acc;
		logic [LW-1:0] layer;
		logic [EW-1:0] expert;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             accepted;
		logic             resident;
		logic [5:0]       slot;
		logic [4:0]       report_layer;
		logic             promoted;
		logic [5:0]       promoted_expert;
		logic [5:0]       evicted_expert;
		logic             last;
		logic [TOT_W-1:0] hit_total;
		logic [TOT_W-1:0] miss_total;
		logic [TOT_W-1:0] promotion_total;
	} res_t;

	function automatic logic [TOT_W-1:0] sat_inc48(input logic [TOT_W-1:0] v);
		return (v == SAT48) ? v : v + 1'b1;
	endfunction
endpackage
`default_nettype wire

FILE: sv/erm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module erm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: sv/erm_front.sv
// front end: accepts items, classifies accesses and queues commands
`default_nettype none
module erm_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire erm_pkg::cfg_t      cfg,
	input  wire logic               hold,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               func,
	input  wire logic [5:0]         layer,
	input  wire logic [5:0]         expert,
	output logic                    cmd_valid,
	output erm_pkg::cmd_t           cmd,
	input  wire logic               cmd_pop
);
	import erm_pkg::*;

	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       take;
	cmd_t       c_new;

	assign full      = (cnt_q == 2'd2) || hold;
	assign take      = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rp_q];

	always_comb begin
		c_new.func   = func;
		c_new.acc    = (layer < cfg.nl) && ({1'b0, expert} < cfg.ne);
		c_new.layer  = layer[LW-1:0];
		c_new.expert = expert;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			q_q[wp_q] <= c_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (take) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, take} - {1'b0, cmd_pop};
		end
	end
endmodule
`default_nettype wire

FILE: sv/erm_outq.sv
// two-entry result queue between the back end and the result ports
`default_nettype none
module erm_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire erm_pkg::res_t wdata,
	output logic               full,
	output logic               empty,
	input  wire logic          pop,
	output erm_pkg::res_t      rdata
);
	import erm_pkg::*;

	res_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       rd;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rd    = pop && !empty;
	assign rdata = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			q_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

FILE: sv/erm_back.sv
// back end: access updates, epoch sweeps and clearing pass over the tables
`default_nettype none
module erm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire erm_pkg::cfg_t cfg,
	input  wire logic          clear_req,
	output logic               clearing,
	input  wire logic          cmd_valid,
	input  wire erm_pkg::cmd_t cmd,
	output logic               cmd_pop,
	input  wire logic          out_full,
	output logic               out_push,
	output erm_pkg::res_t      out_res
);
	import erm_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_ACC   = 3'd2;
	localparam logic [2:0] S_PASS  = 3'd3;
	localparam logic [2:0] S_DEC   = 3'd4;
	localparam logic [2:0] S_REP   = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     addr_q;
	logic [LW-1:0]     layer_q;
	logic [EW:0]       e_q;
	logic [TICK_W-1:0] ticks_q;
	logic [TOT_W-1:0]  hits_q, misses_q, proms_q;

	// sweep pipeline
	logic              v_s1, v_s2;
	logic [EW-1:0]     e_s1, e_s2;
	logic [47:0]       prod_s2;
	logic [CNT_W-1:0]  cnt_s2;
	logic [SLOT_W-1:0] slot_s2;

	logic              have_best_q, have_cold_q, prom_q;
	logic [SCORE_W-1:0] hot_q, coldv_q;
	logic [EW-1:0]     best_q, cold_slot_q, cold_exp_q;

	// ram ports
	logic               sc_we, cn_we, sl_we;
	logic [AW-1:0]      sc_wa, cn_wa, sl_wa, raddr;
	logic [SCORE_W-1:0] sc_wd, sc_rd;
	logic [CNT_W-1:0]   cn_wd, cn_rd;
	logic [SLOT_W-1:0]  sl_wd, sl_rd;

	logic               issue, pass_done, tick_sat, rebal, last_layer, prom;
	logic [TICK_W-1:0]  ticks_new;
	logic [47:0]        rnd;
	logic [32:0]        sum, margin;
	logic [SCORE_W-1:0] newsc;
	logic               upd_best, upd_cold;
	logic               hit_inc, miss_inc, prom_inc, ticks_load, ticks_clr, start_pass;
	logic [TOT_W-1:0]   hits_n, misses_n, proms_n;

	erm_ram #(.WIDTH(SCORE_W), .DEPTH(DEPTH)) u_score (
		.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(raddr), .rdata(sc_rd)
	);
	erm_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_count (
		.clk(clk), .we(cn_we), .waddr(cn_wa), .wdata(cn_wd), .raddr(raddr), .rdata(cn_rd)
	);
	erm_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_slot (
		.clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(raddr), .rdata(sl_rd)
	);

	assign clearing   = (state_q == S_CLEAR);
	assign issue      = (state_q == S_PASS) && (e_q < cfg.ne);
	assign pass_done  = (state_q == S_PASS) && !issue && !v_s1 && !v_s2;
	assign tick_sat   = (ticks_q == {TICK_W{1'b1}});
	assign ticks_new  = tick_sat ? ticks_q : ticks_q + 1'b1;
	assign rebal      = (cfg.period != '0) && (ticks_new >= cfg.period);
	assign last_layer = ({1'b0, layer_q} == cfg.nl - 6'd1);

	// decay with round half up, then add the epoch count shifted left by 8, saturating
	assign rnd   = prod_s2 + 48'h8000;
	assign sum   = {1'b0, rnd[47:16]} + {9'd0, cnt_s2, 8'd0};
	assign newsc = sum[32] ? {SCORE_W{1'b1}} : sum[31:0];

	assign upd_best = v_s2 && slot_s2[6] && (!have_best_q || newsc > hot_q);
	assign upd_cold = v_s2 && !slot_s2[6] && (!have_cold_q || newsc < coldv_q
		|| (newsc == coldv_q && slot_s2[5:0] < cold_slot_q));

	assign margin = {1'b0, coldv_q} + {1'b0, cfg.hyst};
	assign prom   = have_best_q && ({1'b0, hot_q} > margin);

	assign hits_n   = hit_inc ? sat_inc48(hits_q) : hits_q;
	assign misses_n = miss_inc ? sat_inc48(misses_q) : misses_q;
	assign proms_n  = prom_inc ? sat_inc48(proms_q) : proms_q;

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		out_push   = 1'b0;
		out_res    = '0;
		hit_inc    = 1'b0;
		miss_inc   = 1'b0;
		prom_inc   = 1'b0;
		ticks_load = 1'b0;
		ticks_clr  = 1'b0;
		start_pass = 1'b0;
		raddr      = addr_q;
		sc_we      = 1'b0;
		sc_wa      = {layer_q, e_s2};
		sc_wd      = newsc;
		cn_we      = 1'b0;
		cn_wa      = {layer_q, e_s2};
		cn_wd      = '0;
		sl_we      = 1'b0;
		sl_wa      = {layer_q, best_q};
		sl_wd      = {1'b0, cold_slot_q};

		case (state_q)
			S_CLEAR: begin
				sc_we = 1'b1;
				cn_we = 1'b1;
				sl_we = 1'b1;
				sc_wa = clr_q[AW-1:0];
				cn_wa = clr_q[AW-1:0];
				sl_wa = clr_q[AW-1:0];
				sc_wd = '0;
				sl_wd = ({1'b0, clr_q[EW-1:0]} < cfg.nr) ? {1'b0, clr_q[EW-1:0]} : NOT_RES;
				if (clr_q[AW-1:0] == {AW{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				raddr = {cmd.layer, cmd.expert};
				if (cmd_valid) begin
					if (cmd.func == FUNC_ACCESS && cmd.acc) begin
						cmd_pop = 1'b1;
						state_d = S_ACC;
					end else if (cmd.func == FUNC_TICK && rebal) begin
						cmd_pop    = 1'b1;
						ticks_clr  = 1'b1;
						start_pass = 1'b1;
						state_d    = S_PASS;
					end else if (!out_full) begin
						cmd_pop  = 1'b1;
						out_push = 1'b1;
						out_res.last = 1'b1;
						if (cmd.func == FUNC_TICK) begin
							ticks_load   = 1'b1;
							out_res.kind = KIND_TICK;
						end else begin
							out_res.kind = KIND_ACCESS;
						end
					end
				end
			end
			S_ACC: begin
				if (!out_full) begin
					cn_we    = 1'b1;
					cn_wa    = addr_q;
					cn_wd    = (cn_rd == {CNT_W{1'b1}}) ? cn_rd : cn_rd + 1'b1;
					out_push = 1'b1;
					out_res.kind     = KIND_ACCESS;
					out_res.accepted = 1'b1;
					out_res.last     = 1'b1;
					if (!sl_rd[6]) begin
						hit_inc          = 1'b1;
						out_res.resident = 1'b1;
						out_res.slot     = sl_rd[5:0];
					end else begin
						miss_inc = 1'b1;
					end
					state_d = S_IDLE;
				end
			end
			S_PASS: begin
				raddr = {layer_q, e_q[EW-1:0]};
				if (v_s2) begin
					sc_we = 1'b1;
					cn_we = 1'b1;
				end
				if (pass_done) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (prom) begin
					sl_we = 1'b1;
				end
				state_d = S_REP;
			end
			S_REP: begin
				if (!out_full) begin
					if (prom_q) begin
						sl_we    = 1'b1;
						sl_wa    = {layer_q, cold_exp_q};
						sl_wd    = NOT_RES;
						prom_inc = 1'b1;
						out_res.promoted        = 1'b1;
						out_res.promoted_expert = best_q;
						out_res.evicted_expert  = cold_exp_q;
					end
					out_push = 1'b1;
					out_res.kind         = KIND_REPORT;
					out_res.report_layer = 5'(layer_q);
					out_res.last         = last_layer;
					if (last_layer) begin
						state_d = S_IDLE;
					end else begin
						start_pass = 1'b1;
						state_d    = S_PASS;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (clear_req) begin
			state_d = S_CLEAR;
		end
		out_res.hit_total       = hits_n;
		out_res.miss_total      = misses_n;
		out_res.promotion_total = proms_n;
	end

	always_ff @(posedge clk) begin
		e_s1    <= e_q[EW-1:0];
		e_s2    <= e_s1;
		prod_s2 <= {16'd0, sc_rd} * {32'd0, cfg.decay};
		cnt_s2  <= cn_rd;
		slot_s2 <= sl_rd;
		if (state_q == S_IDLE) begin
			addr_q <= {cmd.layer, cmd.expert};
		end
		if (state_q == S_DEC) begin
			prom_q <= prom;
		end
		if (upd_best) begin
			hot_q  <= newsc;
			best_q <= e_s2;
		end
		if (upd_cold) begin
			coldv_q     <= newsc;
			cold_slot_q <= slot_s2[5:0];
			cold_exp_q  <= e_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			layer_q     <= '0;
			e_q         <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			have_best_q <= 1'b0;
			have_cold_q <= 1'b0;
			ticks_q     <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			proms_q     <= '0;
		end else begin
			state_q  <= state_d;
			hits_q   <= hits_n;
			misses_q <= misses_n;
			proms_q  <= proms_n;
			v_s1     <= issue;
			v_s2     <= v_s1;
			if (clear_req) begin
				clr_q <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ticks_clr) begin
				ticks_q <= '0;
			end else if (ticks_load) begin
				ticks_q <= ticks_new;
			end
			if (issue) begin
				e_q <= e_q + 1'b1;
			end
			if (upd_best) begin
				have_best_q <= 1'b1;
			end
			if (upd_cold) begin
				have_cold_q <= 1'b1;
			end
			if (start_pass) begin
				e_q         <= '0;
				have_best_q <= 1'b0;
				have_cold_q <= 1'b0;
				layer_q     <= (state_q == S_IDLE) ? '0 : layer_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/expert_residency_manager.sv
// top level of the expert residency manager
//
// channel | handshake              | carries
// input   | push / full            | func, layer, expert, last_pick
// result  | empty / pop            | kind .. promotion_total
// config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an access in the back end reads the count and slot, then writes the count back
// a tick that ends an epoch sweeps every managed layer
// after reset, and after a write of num_experts, num_resident or num_layers, a clearing
// pass rewrites all 2048 table entries; full stays high during it
// the result queue lets the back end run ahead while results wait to be popped
`default_nettype none
module expert_residency_manager (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        func,
	input  wire logic [5:0]  layer,
	input  wire logic [5:0]  expert,
	input  wire logic        last_pick,
	output logic             empty,
	input  wire logic        pop,
	output logic [1:0]       kind,
	output logic             accepted,
	output logic             resident,
	output logic [5:0]       slot,
	output logic [4:0]       report_layer,
	output logic             promoted,
	output logic [5:0]       promoted_expert,
	output logic [5:0]       evicted_expert,
	output logic             last,
	output logic [47:0]      hit_total,
	output logic [47:0]      miss_total,
	output logic [47:0]      promotion_total,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import erm_pkg::*;

	logic [6:0]        num_experts_q;
	logic [5:0]        num_resident_q, num_layers_q;
	logic [15:0]       decay_q;
	logic [31:0]       hyst_q;
	logic [TICK_W-1:0] period_q;
	logic              cfg_wr, clear_q, clearing;
	cfg_t              cfg;
	logic              cmd_valid, cmd_pop, out_full, out_push;
	cmd_t              cmd;
	res_t              out_res, head;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// clamp the geometry registers to usable values
	always_comb begin
		if (num_experts_q < 7'd2) begin
			cfg.ne = 7'd2;
		end else if (num_experts_q > 7'(EXPERTS)) begin
			cfg.ne = 7'(EXPERTS);
		end else begin
			cfg.ne = num_experts_q;
		end
		if (num_resident_q == 6'd0) begin
			cfg.nr = 6'd1;
		end else if ({1'b0, num_resident_q} > cfg.ne - 7'd1) begin
			cfg.nr = 6'(cfg.ne - 7'd1);
		end else begin
			cfg.nr = num_resident_q;
		end
		if (num_layers_q == 6'd0) begin
			cfg.nl = 6'd1;
		end else if (num_layers_q > 6'(LAYERS)) begin
			cfg.nl = 6'(LAYERS);
		end else begin
			cfg.nl = num_layers_q;
		end
		cfg.decay  = decay_q;
		cfg.hyst   = hyst_q;
		cfg.period = period_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_experts_q  <= 7'd64;
			num_resident_q <= 6'd16;
			num_layers_q   <= 6'd32;
			decay_q        <= 16'd58982;
			hyst_q         <= 32'd256;
			period_q       <= 20'd256;
			clear_q        <= 1'b0;
		end else begin
			clear_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					REG_NUM_EXPERTS: begin
						num_experts_q <= cfg_data[6:0];
						clear_q       <= 1'b1;
					end
					REG_NUM_RESIDENT: begin
						num_resident_q <= cfg_data[5:0];
						clear_q        <= 1'b1;
					end
					REG_NUM_LAYERS: begin
						num_layers_q <= cfg_data[5:0];
						clear_q      <= 1'b1;
					end
					REG_DECAY: begin
						decay_q <= cfg_data[15:0];
					end
					REG_HYSTERESIS: begin
						hyst_q <= cfg_data;
					end
					REG_PERIOD: begin
						period_q <= cfg_data[TICK_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	erm_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .hold(clearing || clear_q),
		.push(push), .full(full), .func(func), .layer(layer), .expert(expert),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
	);

	erm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .clear_req(clear_q), .clearing(clearing),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.out_full(out_full), .out_push(out_push), .out_res(out_res)
	);

	erm_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr(out_push), .wdata(out_res), .full(out_full),
		.empty(empty), .pop(pop), .rdata(head)
	);

	assign kind            = head.kind;
	assign accepted        = head.accepted;
	assign resident        = head.resident;
	assign slot            = head.slot;
	assign report_layer    = head.report_layer;
	assign promoted        = head.promoted;
	assign promoted_expert = head.promoted_expert;
	assign evicted_expert  = head.evicted_expert;
	assign last            = head.last;
	assign hit_total       = head.hit_total;
	assign miss_total      = head.miss_total;
	assign promotion_total = head.promotion_total;
endmodule
`default_nettype wire

FILE: sv/erm_checker.sv
// port-level checks on the expert residency manager and their binding
`default_nettype none
module erm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [1:0]  kind,
	input wire logic        resident,
	input wire logic [5:0]  slot,
	input wire logic        promoted,
	input wire logic [5:0]  promoted_expert,
	input wire logic [5:0]  evicted_expert,
	input wire logic        last,
	input wire logic [47:0] hit_total
);
	import erm_pkg::*;

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == KIND_ACCESS || kind == KIND_TICK || kind == KIND_REPORT))
		else $error("bad result kind");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && kind != KIND_REPORT |-> last)
		else $error("single result without last");

	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !resident |-> slot == 6'd0)
		else $error("slot set on a miss");

	a_swap: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !promoted |-> promoted_expert == 6'd0 && evicted_expert == 6'd0)
		else $error("swap experts without promotion");

	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty |=> empty || hit_total >= $past(hit_total))
		else $error("hit total went down");
endmodule

bind expert_residency_manager erm_checker u_erm_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .kind(kind),
	.resident(resident), .slot(slot), .promoted(promoted),
	.promoted_expert(promoted_expert), .evicted_expert(evicted_expert),
	.last(last), .hit_total(hit_total)
);
`default_nettype wire

FILE: tb/tb_expert_residency_manager.sv
// self-checking testbench for the expert residency manager
`timescale 1ns / 1ps
import erm_pkg::*;

class residency_scoreboard;
	// predicted block state
	logic [31:0] score [DEPTH];
	logic [15:0] hits_cnt [DEPTH];
	logic [5:0]  owner [DEPTH];
	logic [6:0]  where [DEPTH];
	logic [19:0] ticks;
	logic [47:0] hits, misses, proms;
	logic [6:0]  r_ne;
	logic [5:0]  r_nr, r_nl;
	logic [15:0] r_decay;
	logic [31:0] r_hyst;
	logic [19:0] r_period;
	res_t        pending [$];
	int          errors;
	int          checked;
	int          reports;
	int          swaps;

	function new();
		errors = 0;
		checked = 0;
		reports = 0;
		swaps = 0;
		r_ne = 64;
		r_nr = 16;
		r_nl = 32;
		r_decay = 58982;
		r_hyst = 256;
		r_period = 256;
		ticks = 0;
		hits = 0;
		misses = 0;
		proms = 0;
		clear_tables();
	endfunction

	function int n_exp();
		return (r_ne < 2) ? 2 : (r_ne > EXPERTS) ? EXPERTS : int'(r_ne);
	endfunction

	function int n_res();
		int ne;
		ne = n_exp();
		return (r_nr < 1) ? 1 : (r_nr > ne - 1) ? ne - 1 : int'(r_nr);
	endfunction

	function int n_lay();
		return (r_nl < 1) ? 1 : (r_nl > 32) ? 32 : int'(r_nl);
	endfunction

	function void clear_tables();
		int nr;
		nr = n_res();
		for (int i = 0; i < DEPTH; i++) begin
			score[i] = 0;
			hits_cnt[i] = 0;
			owner[i] = 6'(i % EXPERTS);
			where[i] = ((i % EXPERTS) < nr) ? 7'(i % EXPERTS) : NOT_RES;
		end
	endfunction

	function void config_write(logic [2:0] idx, logic [31:0] data);
		case (idx)
			REG_NUM_EXPERTS: begin
				r_ne = data[6:0];
				clear_tables();
			end
			REG_NUM_RESIDENT: begin
				r_nr = data[5:0];
				clear_tables();
			end
			REG_NUM_LAYERS: begin
				r_nl = data[5:0];
				clear_tables();
			end
			REG_DECAY: r_decay = data[15:0];
			REG_HYSTERESIS: r_hyst = data;
			REG_PERIOD: r_period = data[19:0];
			default: ;
		endcase
	endfunction

	function res_t blank();
		res_t r;
		r = '0;
		r.last = 1'b1;
		return r;
	endfunction

	function void stamp(ref res_t r);
		r.hit_total = hits;
		r.miss_total = misses;
		r.promotion_total = proms;
	endfunction

	// epoch end for one layer: decay, pick hottest outsider and coldest slot, maybe swap
	function res_t rebalance(int l);
		res_t r;
		int ne, nr, base, best, cold, old;
		bit have;
		logic [63:0] v;
		logic [31:0] hot, coldv;
		ne = n_exp();
		nr = n_res();
		base = l * EXPERTS;
		have = 0;
		best = 0;
		cold = 0;
		hot = 0;
		coldv = 0;
		for (int e = 0; e < ne; e++) begin
			v = (64'(score[base+e]) * 64'(r_decay) + 64'h8000) >> 16;
			v = v + (64'(hits_cnt[base+e]) << 8);
			score[base+e] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
			hits_cnt[base+e] = 0;
		end
		for (int e = 0; e < ne; e++)
			if (where[base+e][6] && (!have || score[base+e] > hot)) begin
				hot = score[base+e];
				best = e;
				have = 1;
			end
		for (int s = 0; s < nr; s++)
			if (s == 0 || score[base+owner[base+s]] < coldv) begin
				coldv = score[base+owner[base+s]];
				cold = s;
			end
		r = '0;
		r.kind = KIND_REPORT;
		r.report_layer = 5'(l);
		if (have && 64'(hot) > 64'(coldv) + 64'(r_hyst)) begin
			old = owner[base+cold];
			where[base+old] = NOT_RES;
			owner[base+cold] = 6'(best);
			where[base+best] = 7'(cold);
			proms = sat_inc48(proms);
			r.promoted = 1'b1;
			r.promoted_expert = 6'(best);
			r.evicted_expert = 6'(old);
			swaps++;
		end
		return r;
	endfunction

	function void note_input(logic f, logic [5:0] l, logic [5:0] e);
		res_t r;
		int idx, nl;
		if (f == FUNC_ACCESS) begin
			r = blank();
			if (l < n_lay() && e < n_exp()) begin
				idx = l * EXPERTS + e;
				if (hits_cnt[idx] != 16'hFFFF) hits_cnt[idx]++;
				r.accepted = 1'b1;
				if (!where[idx][6]) begin
					hits = sat_inc48(hits);
					r.resident = 1'b1;
					r.slot = where[idx][5:0];
				end else
					misses = sat_inc48(misses);
			end
			stamp(r);
			pending.insert(pending.size(), r);
		end else begin
			if (ticks != 20'hFFFFF) ticks++;
			if (r_period != 0 && ticks >= r_period) begin
				ticks = 0;
				nl = n_lay();
				reports++;
				for (int i = 0; i < nl; i++) begin
					r = rebalance(i);
					r.last = (i == nl - 1);
					stamp(r);
					pending.insert(pending.size(), r);
				end
			end else begin
				r = blank();
				r.kind = KIND_TICK;
				stamp(r);
				pending.insert(pending.size(), r);
			end
		end
	endfunction

	function void field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(res_t got);
		res_t w;
		if (pending.size() == 0) begin
			$error("result beat with nothing outstanding");
			errors++;
			return;
		end
		w = pending.pop_front();
		checked++;
		field("kind", w.kind, got.kind);
		field("accepted", w.accepted, got.accepted);
		field("resident", w.resident, got.resident);
		field("slot", w.slot, got.slot);
		field("report_layer", w.report_layer, got.report_layer);
		field("promoted", w.promoted, got.promoted);
		field("promoted_expert", w.promoted_expert, got.promoted_expert);
		field("evicted_expert", w.evicted_expert, got.evicted_expert);
		field("last", w.last, got.last);
		field("hit_total", w.hit_total, got.hit_total);
		field("miss_total", w.miss_total, got.miss_total);
		field("promotion_total", w.promotion_total, got.promotion_total);
	endfunction
endclass

module tb_expert_residency_manager;
	// index past the last register, writes to it are ignored
	localparam logic [2:0] REG_SPARE = 3'd6;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        func;
	logic [5:0]  layer;
	logic [5:0]  expert;
	logic        last_pick;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic        accepted;
	logic        resident;
	logic [5:0]  slot;
	logic [4:0]  report_layer;
	logic        promoted;
	logic [5:0]  promoted_expert;
	logic [5:0]  evicted_expert;
	logic        last;
	logic [47:0] hit_total;
	logic [47:0] miss_total;
	logic [47:0] promotion_total;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	residency_scoreboard sb;
	bit quiet;
	int sent;

	expert_residency_manager dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// result side: check on each accepted beat, stall at random
	always @(posedge clk) begin
		res_t got;
		if (arst_n && pop && !empty) begin
			got.kind = kind;
			got.accepted = accepted;
			got.resident = resident;
			got.slot = slot;
			got.report_layer = report_layer;
			got.promoted = promoted;
			got.promoted_expert = promoted_expert;
			got.evicted_expert = evicted_expert;
			got.last = last;
			got.hit_total = hit_total;
			got.miss_total = miss_total;
			got.promotion_total = promotion_total;
			sb.check_result(got);
		end
		pop <= quiet || ($urandom_range(99) >= 21);
	end

	task automatic send(logic f, logic [5:0] l, logic [5:0] e);
		if (!quiet && $urandom_range(99) < 21) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		layer <= l;
		expert <= e;
		last_pick <= 1'($urandom_range(1));
		do @(posedge clk); while (full);
		sb.note_input(f, l, e);
		sent++;
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.config_write(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly in-range accesses skewed to low experts so outsiders heat up
	task automatic random_items(int n, int tick_pct);
		logic [5:0] l, e;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < tick_pct)
				send(FUNC_TICK, 6'($urandom), 6'($urandom));
			else begin
				if ($urandom_range(9) == 0) begin
					l = 6'($urandom);
					e = 6'($urandom);
				end else begin
					l = 6'($urandom_range(sb.n_lay() - 1));
					e = ($urandom_range(1)) ? 6'($urandom_range(sb.n_exp() - 1))
						: 6'($urandom_range((sb.n_exp() - 1) / 3 + 1));
				end
				send(FUNC_ACCESS, l, e);
			end
		end
	endtask

	initial begin
		sb = new();
		sent = 0;
		quiet = 0;
		arst_n <= 1'b0;
		push <= 1'b0;
		func <= FUNC_ACCESS;
		layer <= '0;
		expert <= '0;
		last_pick <= 1'b0;
		pop <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_NUM_EXPERTS;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// defaults: field extremes and rejected accesses
		send(FUNC_ACCESS, 6'd0, 6'd0);
		send(FUNC_ACCESS, 6'd31, 6'd63);
		send(FUNC_ACCESS, 6'd63, 6'd0);
		send(FUNC_ACCESS, 6'd0, 6'd63);
		send(FUNC_ACCESS, 6'd32, 6'd15);
		send(FUNC_ACCESS, 6'd5, 6'd16);
		send(FUNC_TICK, 6'd63, 6'd63);
		drain();

		// smallest geometry, no decay, no margin, short epochs
		write_reg(REG_NUM_EXPERTS, 32'd2);
		write_reg(REG_NUM_RESIDENT, 32'd1);
		write_reg(REG_NUM_LAYERS, 32'd1);
		write_reg(REG_DECAY, 32'd0);
		write_reg(REG_HYSTERESIS, 32'd0);
		write_reg(REG_PERIOD, 32'd2);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		send(FUNC_ACCESS, 6'd0, 6'd1);
		send(FUNC_ACCESS, 6'd0, 6'd1);
		send(FUNC_TICK, 6'd0, 6'd0);
		send(FUNC_TICK, 6'd0, 6'd0);
		send(FUNC_ACCESS, 6'd0, 6'd1);
		send(FUNC_ACCESS, 6'd0, 6'd2);
		send(FUNC_ACCESS, 6'd1, 6'd0);
		send(FUNC_TICK, 6'd0, 6'd0);
		send(FUNC_TICK, 6'd0, 6'd0);
		random_items(30, 25);
		drain();

		// clamped geometry writes, widest settings, rebalancing off
		write_reg(REG_NUM_EXPERTS, 32'd127);
		write_reg(REG_NUM_RESIDENT, 32'd63);
		write_reg(REG_NUM_LAYERS, 32'd0);
		write_reg(REG_NUM_LAYERS, 32'd63);
		write_reg(REG_DECAY, 32'd65535);
		write_reg(REG_HYSTERESIS, 32'hFFFF_FFFF);
		write_reg(REG_PERIOD, 32'd0);
		quiet = 1;
		random_items(40, 20);
		quiet = 0;
		drain();

		// mid-size geometry with frequent epochs
		write_reg(REG_NUM_EXPERTS, 32'd8);
		write_reg(REG_NUM_RESIDENT, 32'd3);
		write_reg(REG_NUM_LAYERS, 32'd4);
		write_reg(REG_DECAY, 32'd32768);
		write_reg(REG_HYSTERESIS, 32'd256);
		write_reg(REG_PERIOD, 32'd5);
		random_items(70, 15);
		drain();

		// period lowered below the running tick count
		send(FUNC_TICK, 6'd0, 6'd0);
		send(FUNC_TICK, 6'd0, 6'd0);
		send(FUNC_TICK, 6'd0, 6'd0);
		drain();
		write_reg(REG_PERIOD, 32'd1);
		write_reg(REG_HYSTERESIS, 32'd0);
		write_reg(REG_DECAY, 32'd58982);
		random_items(40, 20);
		drain();

		$display("sent %0d items, checked %0d result beats", sent, sb.checked);
		$display("%0d epoch ends, %0d promotions", sb.reports, sb.swaps);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
